/* rtl/core/tmq_pkg.sv */
package tmq_pkg;

    // Operation codes carried in the kind field of an input word.
    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ENABLED      = 2'd0;
    localparam logic [1:0] CFG_ACH_SHOWN    = 2'd1;
    localparam logic [1:0] CFG_NORMAL_DUR   = 2'd2;
    localparam logic [1:0] CFG_ACH_DUR      = 2'd3;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned DUR_W      = 18;

    // Input word.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
        logic        is_achievement;
        logic [7:0]  message_tag;
    } t_item;

    // Result word.
    typedef struct packed {
        logic [3:0] entry_count;
        logic       accepted;
        logic       suppressed;
        logic       dropped_oldest;
        logic [3:0] expired_count;
        logic [7:0] oldest_tag;
        logic       oldest_is_achievement;
    } t_res;

    // One stored queue entry.
    typedef struct packed {
        logic [7:0]       tag;
        logic             is_ach;
        logic [31:0]      start_ms;
        logic [DUR_W-1:0] dur_ms;
    } t_entry;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TICK,
        ST_HEAD,
        ST_HCAP,
        ST_OUT
    } t_state;

    // Seconds to milliseconds: s * 1000 = s * 1024 - s * 16 - s * 8.
    function automatic logic [DUR_W-1:0] ms_from_s(input logic [7:0] s);
        logic [DUR_W-1:0] ext;
        ext = DUR_W'(s);
        return (ext << 10) - (ext << 4) - (ext << 3);
    endfunction

endpackage

/* rtl/core/tmq_mem.sv */
module tmq_mem
    import tmq_pkg::*;
#(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Single read port with registered data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/tmq_expiry_cmp.sv */
module tmq_expiry_cmp
    import tmq_pkg::*;
(
    input  logic [31:0]      i_now_ms,
    input  logic [31:0]      i_start_ms,
    input  logic [DUR_W-1:0] i_dur_ms,
    output logic             o_expired
);

    logic [31:0] elapsed;

    // Wrapping elapsed time compared against the entry lifetime.
    always_comb begin
        elapsed   = i_now_ms - i_start_ms;
        o_expired = (elapsed >= 32'(i_dur_ms));
    end

endmodule

/* rtl/core/timed_message_queue_with_expiry.sv */
// Sequence: a push, clear or ignored word is accepted in ST_IDLE and passes ST_DECODE, ST_HEAD,
// ST_HCAP and ST_OUT; an enabled tick also passes ST_TICK after ST_DECODE, which reads every entry held,
// as the single expiry comparator walks the entries one per cycle from one memory port.
// Throughput: one word at a time; the next word is accepted the cycle after the result is taken.
// Reset (synchronous, active low): queue empty, configuration at defaults, entry memory
// left as it is; no clearing pass is needed.
module timed_message_queue_with_expiry
    import tmq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_item                 i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_res                  o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SW = CW + 1;

    // Circular index: base plus offset, folded back into the queue depth.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(QUEUE_DEPTH)) begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    t_state          r_state, n_state;
    t_item           r_in, n_in;
    t_res            r_res, n_res;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_rd_idx, n_rd_idx;
    logic [CW-1:0]   r_keep, n_keep;
    logic [CW-1:0]   r_expired, n_expired;
    logic            r_rd_vld, n_rd_vld;

    logic            r_enabled;
    logic            r_ach_shown;
    logic [7:0]      r_normal_dur;
    logic [7:0]      r_ach_dur;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [AW-1:0]   mem_raddr;
    t_entry          mem_wdata;
    t_entry          mem_rdata;
    t_entry          new_entry;
    logic            w_expired;
    logic            push_ok;
    logic            is_full;
    logic            rd_issue;

    // Entry store.
    tmq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Shared expiry comparator, fed by the entry just read.
    tmq_expiry_cmp u_cmp (
        .i_now_ms   (r_in.now_ms),
        .i_start_ms (mem_rdata.start_ms),
        .i_dur_ms   (mem_rdata.dur_ms),
        .o_expired  (w_expired)
    );

    // Decode helpers.
    always_comb begin
        push_ok  = (r_in.kind == KIND_PUSH) && r_enabled &&
                   !(r_in.is_achievement && !r_ach_shown);
        is_full  = (r_count == CW'(QUEUE_DEPTH));
        rd_issue = (r_rd_idx != r_count);
        new_entry.tag      = r_in.message_tag;
        new_entry.is_ach   = r_in.is_achievement;
        new_entry.start_ms = r_in.now_ms;
        new_entry.dur_ms   = ms_from_s(r_in.is_achievement ? r_ach_dur : r_normal_dur);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled    <= 1'b0;
            r_ach_shown  <= 1'b1;
            r_normal_dur <= 8'd2;
            r_ach_dur    <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLED: begin
                    r_enabled <= i_cfg_data[0];
                end
                CFG_ACH_SHOWN: begin
                    r_ach_shown <= i_cfg_data[0];
                end
                CFG_NORMAL_DUR: begin
                    r_normal_dur <= i_cfg_data;
                end
                CFG_ACH_DUR: begin
                    r_ach_dur <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if ((r_in.kind == KIND_TICK) && r_enabled) begin
                    n_state = ST_TICK;
                end else begin
                    n_state = ST_HEAD;
                end
            end
            ST_TICK: begin
                if (!rd_issue && !r_rd_vld) begin
                    n_state = ST_HEAD;
                end
            end
            ST_HEAD: begin
                n_state = ST_HCAP;
            end
            ST_HCAP: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Handshake and memory port controls.
    always_comb begin
        o_stall   = 1'b1;
        o_valid   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_head;
        mem_wdata = new_entry;
        mem_raddr = r_head;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
            end
            ST_DECODE: begin
                // When full the oldest slot becomes the new tail.
                if (push_ok) begin
                    mem_we    = 1'b1;
                    mem_waddr = is_full ? r_head : wrap_add(r_head, r_count);
                end
            end
            ST_TICK: begin
                mem_raddr = wrap_add(r_head, r_rd_idx);
                if (r_rd_vld && !w_expired) begin
                    mem_we    = 1'b1;
                    mem_waddr = wrap_add(r_head, r_keep);
                    mem_wdata = mem_rdata;
                end
            end
            ST_OUT: begin
                o_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_in      = r_in;
        n_res     = r_res;
        n_head    = r_head;
        n_count   = r_count;
        n_rd_idx  = r_rd_idx;
        n_keep    = r_keep;
        n_expired = r_expired;
        n_rd_vld  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_in = i_item;
                end
            end
            ST_DECODE: begin
                n_res           = '0;
                n_rd_idx        = '0;
                n_keep          = '0;
                n_expired       = '0;
                n_res.accepted  = push_ok;
                n_res.suppressed = (r_in.kind == KIND_PUSH) && !push_ok;
                if (push_ok) begin
                    if (is_full) begin
                        n_head               = wrap_add(r_head, CW'(1));
                        n_res.dropped_oldest = 1'b1;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end else if ((r_in.kind == KIND_CLEAR) && r_enabled) begin
                    n_count = '0;
                end
            end
            ST_TICK: begin
                // Issue one read a cycle; judge the entry read the cycle before.
                if (rd_issue) begin
                    n_rd_idx = r_rd_idx + CW'(1);
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld) begin
                    if (w_expired) begin
                        n_expired = r_expired + CW'(1);
                    end else begin
                        n_keep = r_keep + CW'(1);
                    end
                end
                if (!rd_issue && !r_rd_vld) begin
                    n_count             = r_keep;
                    n_res.expired_count = 4'(r_expired);
                end
            end
            ST_HCAP: begin
                // Head entry is on the read port now.
                n_res.entry_count = 4'(r_count);
                if (r_count != '0) begin
                    n_res.oldest_tag            = mem_rdata.tag;
                    n_res.oldest_is_achievement = mem_rdata.is_ach;
                end else begin
                    n_res.oldest_tag            = '0;
                    n_res.oldest_is_achievement = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_in      <= n_in;
        r_res     <= n_res;
        r_rd_idx  <= n_rd_idx;
        r_keep    <= n_keep;
        r_expired <= n_expired;
    end

    assign o_res = r_res;

`ifndef SYNTH
    // The queue never holds more than its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    // A push is either stored or refused, never both.
    a_push_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_res.accepted && o_res.suppressed))
        else $error("push both accepted and suppressed");

    // Compaction never writes ahead of the entries already read.
    a_keep_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK) |-> (r_keep <= r_rd_idx))
        else $error("compaction write index ahead of read index");

    // An empty queue reports a zero head entry.
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_count == '0)) |->
            ((o_res.oldest_tag == '0) && !o_res.oldest_is_achievement))
        else $error("empty queue reports a head entry");

    // A result is held until it is taken.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_res)))
        else $error("stalled result changed");
`endif

endmodule
